// File: rtl/core/cgdh_pkg.sv
package cgdh_pkg;

    localparam int unsigned SCREEN_COLUMNS = 256;
    localparam int unsigned SCREEN_ROWS    = 256;
    localparam int unsigned ANCHOR_SLOTS   = 8;

    localparam int unsigned PIX_XW    = $clog2(SCREEN_COLUMNS);
    localparam int unsigned PIX_YW    = $clog2(SCREEN_ROWS);
    localparam int unsigned BIN_DEPTH = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int unsigned BIN_AW    = $clog2(BIN_DEPTH);
    localparam int unsigned SLOT_W    = $clog2(ANCHOR_SLOTS);

    localparam int unsigned COORD_W    = 32;
    localparam int unsigned CNT_W      = 32;
    localparam int unsigned FIELD_PIX_W = 8;
    localparam int unsigned IDX_IN_W   = 3;
    localparam int unsigned DF_W       = 17;
    localparam int unsigned FUNC_W     = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned S_TDATA_W  = 88;
    localparam int unsigned M_TDATA_W  = 48;

    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_STEP    = 2'd0,
        FUNC_RESTART = 2'd1,
        FUNC_LOAD    = 2'd2,
        FUNC_READ    = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIST_FACTOR = 3'd0,
        CFG_MIN_X       = 3'd1,
        CFG_MIN_Y       = 3'd2,
        CFG_SCALE_X     = 3'd3,
        CFG_SCALE_Y     = 3'd4,
        CFG_START_X     = 3'd5,
        CFG_START_Y     = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [DF_W-1:0]           dist_factor;
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic [COORD_W-1:0]        scale_x;
        logic [COORD_W-1:0]        scale_y;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        dist_factor: 17'd32768,
        min_x:       '0,
        min_y:       '0,
        scale_x:     32'd65536,
        scale_y:     32'd65536,
        start_x:     '0,
        start_y:     '0
    };

    typedef struct packed {
        func_t                     op;
        logic [SLOT_W-1:0]         slot;
        logic signed [COORD_W-1:0] anchor_x;
        logic signed [COORD_W-1:0] anchor_y;
        logic [FIELD_PIX_W-1:0]    bin_x;
        logic [FIELD_PIX_W-1:0]    bin_y;
        logic                      read_ok;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    typedef struct packed {
        logic clearing;
        logic pop;
    } bk_status_t;

    // Reduces a requested anchor index into the table by repeated subtraction.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [IDX_IN_W-1:0] idx);
        logic [IDX_IN_W:0] v;
        v = {1'b0, idx};
        for (int i = 0; i < (1 << IDX_IN_W); i++) begin
            if (32'(v) >= ANCHOR_SLOTS) begin
                v = v - (IDX_IN_W + 1)'(ANCHOR_SLOTS);
            end
        end
        return SLOT_W'(v);
    endfunction

    function automatic logic [BIN_AW-1:0] bin_addr(input logic [PIX_XW-1:0] px,
                                                   input logic [PIX_YW-1:0] py);
        return BIN_AW'(px) + BIN_AW'(py) * BIN_AW'(SCREEN_COLUMNS);
    endfunction

endpackage

// File: rtl/core/chaos_game_density_histogram_core.sv
// Back-end sequencer: a step runs MUL, MOVE, DIFF, PROD, PIX, FETCH, DONE; a restart starts
// at DIFF; a read runs FETCH, DONE; a load goes to DONE. Items are handled one at a time,
// with two multiply stages (MUL, PROD) and the histogram read-modify-write (FETCH, DONE).
// A two-item queue lets the input side take items while the back end works or stalls.
// Reset (aresetn low, synchronous) clears point, anchors and registers, then a clearing
// pass over all 65536 bins zeroes the histogram; no item is accepted until it is done.
module chaos_game_density_histogram_core import cgdh_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // anchor_index, anchor_x, anchor_y, bin_x, bin_y, zero pad (lowest bit first)
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // func
    input  logic [FUNC_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // pixel_x, pixel_y, bin_count (lowest bit first)
    output logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t       cfg_reg, cfg_next;
    q_head_t    q_head;
    bk_status_t bk_status;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                CFG_DIST_FACTOR: cfg_next.dist_factor = cfg_wdata[DF_W-1:0];
                CFG_MIN_X:       cfg_next.min_x       = $signed(cfg_wdata);
                CFG_MIN_Y:       cfg_next.min_y       = $signed(cfg_wdata);
                CFG_SCALE_X:     cfg_next.scale_x     = cfg_wdata;
                CFG_SCALE_Y:     cfg_next.scale_y     = cfg_wdata;
                CFG_START_X:     cfg_next.start_x     = $signed(cfg_wdata);
                CFG_START_Y:     cfg_next.start_y     = $signed(cfg_wdata);
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    cgdh_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .bk_status (bk_status),
        .q_head    (q_head)
    );

    cgdh_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_head    (q_head),
        .bk_status (bk_status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: rtl/core/cgdh_ram.sv
module cgdh_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/cgdh_front.sv
module cgdh_front import cgdh_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // anchor_index, anchor_x, anchor_y, bin_x, bin_y, zero pad (lowest bit first)
    input  logic [S_TDATA_W-1:0] s_tdata,
    // func
    input  logic [FUNC_W-1:0]    s_tuser,
    input  bk_status_t           bk_status,
    output q_head_t              q_head
);

    item_t              entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    item_t              in_item;
    logic               push;

    always_comb begin
        in_item.op       = func_t'(s_tuser);
        in_item.slot     = slot_of(s_tdata[2:0]);
        in_item.anchor_x = $signed(s_tdata[34:3]);
        in_item.anchor_y = $signed(s_tdata[66:35]);
        in_item.bin_x    = s_tdata[74:67];
        in_item.bin_y    = s_tdata[82:75];
        in_item.read_ok  = (32'(s_tdata[74:67]) < SCREEN_COLUMNS) &&
                           (32'(s_tdata[82:75]) < SCREEN_ROWS);
    end

    assign s_tready = (32'(count_reg) < Q_DEPTH) && !bk_status.clearing;
    assign push     = s_tvalid && s_tready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (32'(wr_ptr_reg) == Q_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (bk_status.pop) begin
            rd_ptr_next = (32'(rd_ptr_reg) == Q_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !bk_status.pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && bk_status.pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

    assign q_head.valid = (count_reg != '0);
    assign q_head.item  = entry_reg[rd_ptr_reg];

endmodule

// File: rtl/core/cgdh_back.sv
module cgdh_back import cgdh_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cfg_t                 cfg,
    input  q_head_t              q_head,
    output bk_status_t           bk_status,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // pixel_x, pixel_y, bin_count (lowest bit first)
    output logic [M_TDATA_W-1:0] m_tdata
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_MOVE,
        ST_DIFF,
        ST_PROD,
        ST_PIX,
        ST_FETCH,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    func_t  op_reg, op_next;

    logic signed [COORD_W-1:0] tab_x_reg [ANCHOR_SLOTS];
    logic signed [COORD_W-1:0] tab_y_reg [ANCHOR_SLOTS];
    logic signed [COORD_W-1:0] tab_x_next [ANCHOR_SLOTS];
    logic signed [COORD_W-1:0] tab_y_next [ANCHOR_SLOTS];

    logic signed [COORD_W-1:0] pt_x_reg, pt_x_next, pt_y_reg, pt_y_next;
    logic signed [COORD_W-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic signed [50:0]        mx_reg, mx_next, my_reg, my_next;
    logic [COORD_W-1:0]        dx_reg, dx_next, dy_reg, dy_next;
    logic                      negx_reg, negx_next, negy_reg, negy_next;
    logic [63:0]               sx_reg, sx_next, sy_reg, sy_next;
    logic [PIX_XW-1:0]         pix_x_reg, pix_x_next;
    logic [PIX_YW-1:0]         pix_y_reg, pix_y_next;
    logic [FIELD_PIX_W-1:0]    res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic                      in_range_reg, in_range_next;
    logic [BIN_AW-1:0]         clr_reg, clr_next;

    logic                      m_valid_reg, m_valid_next;
    logic [FIELD_PIX_W-1:0]    m_px_reg, m_px_next, m_py_reg, m_py_next;
    logic [CNT_W-1:0]          m_cnt_reg, m_cnt_next;

    logic                      ram_we, ram_re;
    logic [BIN_AW-1:0]         ram_waddr, ram_raddr;
    logic [CNT_W-1:0]          ram_wdata, ram_rdata;

    logic signed [COORD_W:0]   diff_x, diff_y, dmin_x, dmin_y;
    logic signed [51:0]        rnd_x, rnd_y;
    logic signed [36:0]        sum_x, sum_y;
    logic [COORD_W:0]          raw_x, raw_y;
    logic [CNT_W-1:0]          inc_cnt;
    logic                      out_free;

    cgdh_ram #(
        .WIDTH(CNT_W),
        .DEPTH(BIN_DEPTH)
    ) u_bins (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign inc_cnt  = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;

    // Datapath terms for each stage of the sequencer.
    always_comb begin
        diff_x = {ax_reg[COORD_W-1], ax_reg} - {pt_x_reg[COORD_W-1], pt_x_reg};
        diff_y = {ay_reg[COORD_W-1], ay_reg} - {pt_y_reg[COORD_W-1], pt_y_reg};
        // Adding one half and shifting arithmetically rounds ties upward.
        rnd_x  = {mx_reg[50], mx_reg} + 52'sd32768;
        rnd_y  = {my_reg[50], my_reg} + 52'sd32768;
        sum_x  = {{5{pt_x_reg[COORD_W-1]}}, pt_x_reg} + {rnd_x[51], rnd_x[51:16]};
        sum_y  = {{5{pt_y_reg[COORD_W-1]}}, pt_y_reg} + {rnd_y[51], rnd_y[51:16]};
        dmin_x = {pt_x_reg[COORD_W-1], pt_x_reg} - {cfg.min_x[COORD_W-1], cfg.min_x};
        dmin_y = {pt_y_reg[COORD_W-1], pt_y_reg} - {cfg.min_y[COORD_W-1], cfg.min_y};
        raw_x  = {1'b0, sx_reg[63:32]} + {{COORD_W{1'b0}}, sx_reg[31]};
        raw_y  = {1'b0, sy_reg[63:32]} + {{COORD_W{1'b0}}, sy_reg[31]};
    end

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        tab_x_next    = tab_x_reg;
        tab_y_next    = tab_y_reg;
        pt_x_next     = pt_x_reg;
        pt_y_next     = pt_y_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        mx_next       = mx_reg;
        my_next       = my_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        negx_next     = negx_reg;
        negy_next     = negy_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        pix_x_next    = pix_x_reg;
        pix_y_next    = pix_y_reg;
        res_x_next    = res_x_reg;
        res_y_next    = res_y_reg;
        in_range_next = in_range_reg;
        clr_next      = clr_reg;
        m_valid_next  = m_valid_reg;
        m_px_next     = m_px_reg;
        m_py_next     = m_py_reg;
        m_cnt_next    = m_cnt_reg;
        ram_we        = 1'b0;
        ram_waddr     = bin_addr(pix_x_reg, pix_y_reg);
        ram_wdata     = inc_cnt;
        ram_re        = 1'b0;
        ram_raddr     = bin_addr(pix_x_reg, pix_y_reg);
        bk_status.pop = 1'b0;
        bk_status.clearing = (state_reg == ST_CLEAR);

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == BIN_AW'(BIN_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_head.valid) begin
                    bk_status.pop = 1'b1;
                    op_next       = q_head.item.op;
                    unique case (q_head.item.op)
                        FUNC_STEP: begin
                            ax_next    = tab_x_reg[q_head.item.slot];
                            ay_next    = tab_y_reg[q_head.item.slot];
                            state_next = ST_MUL;
                        end
                        FUNC_RESTART: begin
                            pt_x_next  = cfg.start_x;
                            pt_y_next  = cfg.start_y;
                            state_next = ST_DIFF;
                        end
                        FUNC_LOAD: begin
                            tab_x_next[q_head.item.slot] = q_head.item.anchor_x;
                            tab_y_next[q_head.item.slot] = q_head.item.anchor_y;
                            res_x_next    = '0;
                            res_y_next    = '0;
                            in_range_next = 1'b0;
                            state_next    = ST_DONE;
                        end
                        FUNC_READ: begin
                            res_x_next    = q_head.item.bin_x;
                            res_y_next    = q_head.item.bin_y;
                            pix_x_next    = PIX_XW'(q_head.item.bin_x);
                            pix_y_next    = PIX_YW'(q_head.item.bin_y);
                            in_range_next = q_head.item.read_ok;
                            state_next    = ST_FETCH;
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MUL: begin
                mx_next    = diff_x * $signed({1'b0, cfg.dist_factor});
                my_next    = diff_y * $signed({1'b0, cfg.dist_factor});
                state_next = ST_MOVE;
            end
            ST_MOVE: begin
                // The sum overflows 32 bits when its upper bits disagree with the sign.
                if (sum_x[36:31] != {6{sum_x[36]}}) begin
                    pt_x_next = sum_x[36] ? {1'b1, {(COORD_W-1){1'b0}}}
                                          : {1'b0, {(COORD_W-1){1'b1}}};
                end else begin
                    pt_x_next = sum_x[COORD_W-1:0];
                end
                if (sum_y[36:31] != {6{sum_y[36]}}) begin
                    pt_y_next = sum_y[36] ? {1'b1, {(COORD_W-1){1'b0}}}
                                          : {1'b0, {(COORD_W-1){1'b1}}};
                end else begin
                    pt_y_next = sum_y[COORD_W-1:0];
                end
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                dx_next    = dmin_x[COORD_W-1:0];
                dy_next    = dmin_y[COORD_W-1:0];
                negx_next  = dmin_x[COORD_W];
                negy_next  = dmin_y[COORD_W];
                state_next = ST_PROD;
            end
            ST_PROD: begin
                sx_next    = negx_reg ? '0 : 64'(dx_reg) * 64'(cfg.scale_x);
                sy_next    = negy_reg ? '0 : 64'(dy_reg) * 64'(cfg.scale_y);
                state_next = ST_PIX;
            end
            ST_PIX: begin
                if (raw_x > (COORD_W + 1)'(SCREEN_COLUMNS - 1)) begin
                    pix_x_next = PIX_XW'(SCREEN_COLUMNS - 1);
                end else begin
                    pix_x_next = raw_x[PIX_XW-1:0];
                end
                if (raw_y > (COORD_W + 1)'(SCREEN_ROWS - 1)) begin
                    pix_y_next = PIX_YW'(SCREEN_ROWS - 1);
                end else begin
                    pix_y_next = raw_y[PIX_YW-1:0];
                end
                in_range_next = 1'b1;
                state_next    = ST_FETCH;
            end
            ST_FETCH: begin
                ram_re = in_range_reg;
                if (op_reg != FUNC_READ) begin
                    res_x_next = FIELD_PIX_W'(pix_x_reg);
                    res_y_next = FIELD_PIX_W'(pix_y_reg);
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_px_next    = res_x_reg;
                    m_py_next    = res_y_reg;
                    case (op_reg) inside
                        FUNC_STEP, FUNC_RESTART: begin
                            ram_we     = 1'b1;
                            m_cnt_next = inc_cnt;
                        end
                        FUNC_READ: begin
                            m_cnt_next = in_range_reg ? ram_rdata : '0;
                        end
                        default: begin
                            m_cnt_next = '0;
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            pt_x_reg    <= '0;
            pt_y_reg    <= '0;
            for (int i = 0; i < ANCHOR_SLOTS; i++) begin
                tab_x_reg[i] <= '0;
                tab_y_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            pt_x_reg    <= pt_x_next;
            pt_y_reg    <= pt_y_next;
            tab_x_reg   <= tab_x_next;
            tab_y_reg   <= tab_y_next;
        end
        op_reg       <= op_next;
        ax_reg       <= ax_next;
        ay_reg       <= ay_next;
        mx_reg       <= mx_next;
        my_reg       <= my_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        negx_reg     <= negx_next;
        negy_reg     <= negy_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        pix_x_reg    <= pix_x_next;
        pix_y_reg    <= pix_y_next;
        res_x_reg    <= res_x_next;
        res_y_reg    <= res_y_next;
        in_range_reg <= in_range_next;
        m_px_reg     <= m_px_next;
        m_py_reg     <= m_py_next;
        m_cnt_reg    <= m_cnt_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_cnt_reg, m_py_reg, m_px_reg};

endmodule

// File: rtl/core/cgdh_checker.sv
module cgdh_checker import cgdh_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // The histogram clearing pass holds off input after reset.
    a_clear_blocks_input: assert property (@(posedge aclk)
        !aresetn |=> !s_tready ##1 !s_tready)
        else $error("input accepted during histogram clear");

    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // No item can produce a result before the clear pass has finished.
    a_no_result_during_clear: assert property (@(posedge aclk)
        !aresetn |=> ##1 !m_tvalid)
        else $error("result valid during histogram clear");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind chaos_game_density_histogram_core cgdh_checker u_cgdh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: dv/chaos_game_density_histogram_core_tb.sv
`timescale 1ns / 1ps

import cgdh_pkg::*;

class density_scoreboard;
    typedef struct {
        logic [FIELD_PIX_W-1:0] px;
        logic [FIELD_PIX_W-1:0] py;
        logic [CNT_W-1:0]       count;
    } hit_t;

    hit_t                      awaited_hits[$];
    int unsigned               hit_counts[BIN_DEPTH];
    logic [DF_W-1:0]           dist_factor;
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] min_y;
    logic [COORD_W-1:0]        scale_x;
    logic [COORD_W-1:0]        scale_y;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] anchor_x_tab[ANCHOR_SLOTS];
    logic signed [COORD_W-1:0] anchor_y_tab[ANCHOR_SLOTS];
    logic [FIELD_PIX_W-1:0]    last_px;
    logic [FIELD_PIX_W-1:0]    last_py;
    int                        errors;

    function new();
        dist_factor = CFG_RESET.dist_factor;
        min_x       = CFG_RESET.min_x;
        min_y       = CFG_RESET.min_y;
        scale_x     = CFG_RESET.scale_x;
        scale_y     = CFG_RESET.scale_y;
        start_x     = CFG_RESET.start_x;
        start_y     = CFG_RESET.start_y;
        point_x     = '0;
        point_y     = '0;
        last_px     = '0;
        last_py     = '0;
        errors      = 0;
        foreach (anchor_x_tab[i]) begin
            anchor_x_tab[i] = '0;
            anchor_y_tab[i] = '0;
        end
        foreach (hit_counts[i]) begin
            hit_counts[i] = 0;
        end
    endfunction

    task report(string what);
        errors++;
        if (errors <= 200) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_DIST_FACTOR: dist_factor = value[DF_W-1:0];
            CFG_MIN_X:       min_x = value;
            CFG_MIN_Y:       min_y = value;
            CFG_SCALE_X:     scale_x = value;
            CFG_SCALE_Y:     scale_y = value;
            CFG_START_X:     start_x = value;
            CFG_START_Y:     start_y = value;
            default:         ;
        endcase
    endfunction

    // Moves one coordinate toward the anchor; the product is rounded half up
    // (a tie goes toward plus infinity) and the sum saturates.
    function logic signed [COORD_W-1:0] advance_coord(logic signed [COORD_W-1:0] p,
                                                      logic signed [COORD_W-1:0] a);
        longint diff;
        longint moved;
        diff  = longint'(a) - longint'(p);
        moved = longint'(p) + ((diff * longint'(dist_factor) + 32768) >>> 16);
        if (moved > 64'sd2147483647) begin
            moved = 64'sd2147483647;
        end else if (moved < -64'sd2147483648) begin
            moved = -64'sd2147483648;
        end
        return moved[COORD_W-1:0];
    endfunction

    function logic [FIELD_PIX_W-1:0] coord_to_pixel(logic signed [COORD_W-1:0] p,
                                                    logic signed [COORD_W-1:0] lo,
                                                    logic [COORD_W-1:0] scale,
                                                    int unsigned size);
        longint      offset;
        logic [63:0] mag;
        logic [63:0] prod;
        logic [32:0] pix;
        offset = longint'(p) - longint'(lo);
        if (offset < 0) begin
            return '0;
        end
        mag  = offset;
        prod = mag * {32'd0, scale};
        pix  = {1'b0, prod[63:32]} + 33'(prod[31]);
        if (pix > 33'(size - 1)) begin
            pix = 33'(size - 1);
        end
        return pix[FIELD_PIX_W-1:0];
    endfunction

    function void count_point();
        logic [FIELD_PIX_W-1:0] px;
        logic [FIELD_PIX_W-1:0] py;
        int unsigned            addr;
        px   = coord_to_pixel(point_x, min_x, scale_x, SCREEN_COLUMNS);
        py   = coord_to_pixel(point_y, min_y, scale_y, SCREEN_ROWS);
        addr = int'(px) + SCREEN_COLUMNS * int'(py);
        if (hit_counts[addr] != 32'hFFFF_FFFF) begin
            hit_counts[addr]++;
        end
        last_px = px;
        last_py = py;
        awaited_hits.push_back('{px: px, py: py, count: hit_counts[addr]});
    endfunction

    function void note_request(func_t op, logic [IDX_IN_W-1:0] idx,
                               logic signed [COORD_W-1:0] ax, logic signed [COORD_W-1:0] ay,
                               logic [FIELD_PIX_W-1:0] bx, logic [FIELD_PIX_W-1:0] by);
        int unsigned slot;
        logic [CNT_W-1:0] count;
        slot = idx % ANCHOR_SLOTS;
        case (op)
            FUNC_STEP: begin
                point_x = advance_coord(point_x, anchor_x_tab[slot]);
                point_y = advance_coord(point_y, anchor_y_tab[slot]);
                count_point();
            end
            FUNC_RESTART: begin
                point_x = start_x;
                point_y = start_y;
                count_point();
            end
            FUNC_LOAD: begin
                anchor_x_tab[slot] = ax;
                anchor_y_tab[slot] = ay;
                awaited_hits.push_back('{px: '0, py: '0, count: '0});
            end
            FUNC_READ: begin
                count = '0;
                if (bx < SCREEN_COLUMNS && by < SCREEN_ROWS) begin
                    count = hit_counts[int'(bx) + SCREEN_COLUMNS * int'(by)];
                end
                awaited_hits.push_back('{px: bx, py: by, count: count});
            end
            default: ;
        endcase
    endfunction

    task check_hit(logic [FIELD_PIX_W-1:0] px, logic [FIELD_PIX_W-1:0] py,
                   logic [CNT_W-1:0] count);
        hit_t want;
        if (awaited_hits.size() == 0) begin
            report($sformatf("result (%0d,%0d) count %0d with nothing outstanding",
                             px, py, count));
            return;
        end
        want = awaited_hits.pop_front();
        if (px !== want.px) begin
            report($sformatf("pixel_x %0d, expected %0d", px, want.px));
        end
        if (py !== want.py) begin
            report($sformatf("pixel_y %0d, expected %0d", py, want.py));
        end
        if (count !== want.count) begin
            report($sformatf("bin_count %0d at (%0d,%0d), expected %0d",
                             count, want.px, want.py, want.count));
        end
    endtask
endclass

module chaos_game_density_histogram_core_tb;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam int     RANDOM_PHASES    = 8;
    localparam int     RANDOM_ITEMS     = 205;
    localparam int     QUIET_AFTER      = 1480;
    localparam int     LONG_HOLD_CYCLES = 400;
    localparam int     DRAIN_LIMIT      = 20000;
    localparam int     SETTLE_CYCLES    = 20;
    localparam longint TIMEOUT_NS       = 12_000_000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [FUNC_W-1:0]     s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    density_scoreboard sb;
    int gap_pct;
    int stall_pct;
    int items_sent;
    bit quiet_tail;
    bit hold_out_req;

    chaos_game_density_histogram_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    // Both handshakes are sampled here, with the values from before the edge.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_request(func_t'(s_tuser), s_tdata[2:0], s_tdata[34:3], s_tdata[66:35],
                            s_tdata[74:67], s_tdata[82:75]);
        end
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_hit(m_tdata[7:0], m_tdata[15:8], m_tdata[47:16]);
        end
    end

    initial begin
        int n;
        m_tready = 1'b1;
        forever begin
            @(negedge aclk);
            if (hold_out_req) begin
                m_tready <= 1'b0;
                for (n = 0; n < LONG_HOLD_CYCLES; n++) begin
                    @(negedge aclk);
                end
                m_tready <= 1'b1;
                hold_out_req = 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
                n = $urandom_range(1, 7);
                m_tready <= 1'b0;
                repeat (n) @(negedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send(func_t op, logic [IDX_IN_W-1:0] idx,
                        logic [COORD_W-1:0] ax, logic [COORD_W-1:0] ay,
                        logic [FIELD_PIX_W-1:0] bx, logic [FIELD_PIX_W-1:0] by);
        int n;
        if (items_sent >= QUIET_AFTER) begin
            quiet_tail = 1'b1;
        end
        if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
            n = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            repeat (n) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'd0, by, bx, ay, ax, idx};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        sb.set_register(idx, value);
        @(negedge aclk);
    endtask

    task automatic drain();
        int waited;
        s_tvalid <= 1'b0;
        waited = 0;
        while (sb.awaited_hits.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
    endtask

    function automatic logic [COORD_W-1:0] near_origin(int unsigned span);
        return COORD_W'(longint'($urandom_range(0, 2 * span)) - longint'(span));
    endfunction

    initial begin
        logic [COORD_W-1:0]     ax;
        logic [COORD_W-1:0]     ay;
        logic [IDX_IN_W-1:0]    idx;
        logic [FIELD_PIX_W-1:0] bx;
        logic [FIELD_PIX_W-1:0] by;
        logic [DF_W-1:0]        df;
        int unsigned            span;
        int unsigned            pick;
        longint                 scale;

        sb           = new();
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = FUNC_STEP;
        cfg_we       = 1'b0;
        cfg_index    = CFG_DIST_FACTOR;
        cfg_wdata    = '0;
        gap_pct      = 0;
        stall_pct    = 0;
        items_sent   = 0;
        quiet_tail   = 1'b0;
        hold_out_req = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: empty histogram, half-way moves, one pixel per unit.
        send(FUNC_READ, 3'd0, '0, '0, 8'd0, 8'd0);
        send(FUNC_RESTART, 3'd0, '0, '0, 8'd0, 8'd0);
        send(FUNC_LOAD, 3'd5, 32'h0005_0000, 32'h000A_0000, 8'd0, 8'd0);
        // Lands on x = 2.5, which rounds up to column 3.
        send(FUNC_STEP, 3'd5, '0, '0, 8'd0, 8'd0);
        send(FUNC_LOAD, 3'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd0, 8'd0);
        send(FUNC_LOAD, 3'd7, 32'h8000_0000, 32'h8000_0000, 8'd0, 8'd0);
        send(FUNC_STEP, 3'd0, '0, '0, 8'd0, 8'd0);
        send(FUNC_STEP, 3'd7, '0, '0, 8'd0, 8'd0);
        send(FUNC_READ, 3'd0, '0, '0, 8'd3, 8'd5);
        send(FUNC_READ, 3'd0, '0, '0, 8'd255, 8'd255);
        send(FUNC_RESTART, 3'd0, '0, '0, 8'd0, 8'd0);
        // A y offset of minus one raw unit makes an exact tie that rounds toward zero.
        send(FUNC_LOAD, 3'd2, 32'hFFFE_8000, 32'hFFFF_FFFF, 8'd0, 8'd0);
        send(FUNC_STEP, 3'd2, '0, '0, 8'd0, 8'd0);
        drain();

        // Full moves, extreme offsets and scales, and a write to the unused index.
        write_reg(CFG_DIST_FACTOR, 32'd65536);
        write_reg(CFG_MIN_X, 32'h8000_0000);
        write_reg(CFG_MIN_Y, 32'h8000_0000);
        write_reg(CFG_SCALE_X, 32'hFFFF_FFFF);
        write_reg(CFG_SCALE_Y, 32'd0);
        write_reg(CFG_START_X, 32'h7FFF_FFFF);
        write_reg(CFG_START_Y, 32'h8000_0000);
        write_reg(CFG_SPARE, 32'hFFFF_FFFF);
        cfg_we <= 1'b0;
        send(FUNC_RESTART, 3'd0, '0, '0, 8'd0, 8'd0);
        send(FUNC_STEP, 3'd7, '0, '0, 8'd0, 8'd0);
        send(FUNC_STEP, 3'd0, '0, '0, 8'd0, 8'd0);
        send(FUNC_READ, 3'd0, '0, '0, 8'd255, 8'd0);
        drain();

        // Moves of nearly twice the distance overshoot and saturate.
        write_reg(CFG_DIST_FACTOR, 32'd131071);
        write_reg(CFG_MIN_X, 32'h7FFF_FFFF);
        write_reg(CFG_MIN_Y, 32'd0);
        write_reg(CFG_SCALE_Y, 32'd65536);
        cfg_we <= 1'b0;
        send(FUNC_STEP, 3'd7, '0, '0, 8'd0, 8'd0);
        send(FUNC_STEP, 3'd0, '0, '0, 8'd0, 8'd0);
        send(FUNC_STEP, 3'd5, '0, '0, 8'd0, 8'd0);
        send(FUNC_READ, 3'd0, '0, '0, 8'd0, 8'd0);
        drain();

        // A zero factor keeps the point still, so one bin keeps counting.
        write_reg(CFG_DIST_FACTOR, 32'd0);
        write_reg(CFG_MIN_X, 32'd0);
        write_reg(CFG_SCALE_X, 32'd65536);
        cfg_we <= 1'b0;
        send(FUNC_STEP, 3'd3, '0, '0, 8'd0, 8'd0);
        send(FUNC_STEP, 3'd3, '0, '0, 8'd0, 8'd0);
        send(FUNC_STEP, 3'd3, '0, '0, 8'd0, 8'd0);
        send(FUNC_READ, 3'd0, '0, '0, sb.last_px, sb.last_py);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            // The screen covers [-span, span] on both axes, sometimes a bit less.
            span = 1 << $urandom_range(12, 30);
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                df = 17'd65536;
            end else if (pick == 1) begin
                df = 17'($urandom_range(65537, 131071));
            end else begin
                df = 17'($urandom_range(4096, 61440));
            end
            scale = (longint'(255) << 32) / (2 * longint'(span));
            if ($urandom_range(0, 3) == 0) begin
                scale += $urandom_range(0, 32'(scale / 4));
            end
            write_reg(CFG_DIST_FACTOR, {15'($urandom), df});
            write_reg(CFG_MIN_X, 32'(-longint'(span)));
            write_reg(CFG_MIN_Y, 32'(-longint'(span)));
            write_reg(CFG_SCALE_X, scale[31:0]);
            write_reg(CFG_SCALE_Y, scale[31:0]);
            write_reg(CFG_START_X, near_origin(span));
            write_reg(CFG_START_Y, near_origin(span));
            cfg_we <= 1'b0;
            gap_pct   = 10 * $urandom_range(0, 3);
            stall_pct = 10 * $urandom_range(0, 3);
            if (ph == 2) begin
                gap_pct = 0;
            end

            for (int s = 0; s < ANCHOR_SLOTS; s++) begin
                send(FUNC_LOAD, IDX_IN_W'(s), near_origin(span), near_origin(span),
                     8'($urandom), 8'($urandom));
            end
            send(FUNC_RESTART, 3'($urandom), $urandom, $urandom, 8'($urandom), 8'($urandom));

            for (int n = 0; n < RANDOM_ITEMS; n++) begin
                if (ph == 2 && n == 60) begin
                    hold_out_req = 1'b1;
                end
                idx  = $urandom;
                ax   = $urandom;
                ay   = $urandom;
                bx   = $urandom;
                by   = $urandom;
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    send(FUNC_RESTART, idx, ax, ay, bx, by);
                end else if (pick < 18) begin
                    // Most anchors stay on screen; the rest land anywhere.
                    if ($urandom_range(0, 4) != 0) begin
                        ax = near_origin(span);
                        ay = near_origin(span);
                    end
                    send(FUNC_LOAD, idx, ax, ay, bx, by);
                end else if (pick < 36) begin
                    if (pick < 27) begin
                        bx = sb.last_px;
                        by = sb.last_py;
                    end
                    send(FUNC_READ, idx, ax, ay, bx, by);
                end else begin
                    send(FUNC_STEP, idx, ax, ay, bx, by);
                end
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (sb.awaited_hits.size() != 0) begin
            sb.report($sformatf("%0d results never arrived", sb.awaited_hits.size()));
        end
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: chaos_game_density_histogram_core.f
rtl/core/cgdh_pkg.sv
rtl/core/cgdh_ram.sv
rtl/core/cgdh_front.sv
rtl/core/cgdh_back.sv
rtl/core/chaos_game_density_histogram_core.sv
rtl/core/cgdh_checker.sv
dv/chaos_game_density_histogram_core_tb.sv
